/* design/compass_heading_unit_macros.svh */
// Assertion macros shared by the compass heading unit checkers.
// No dependencies; include by bare file name.
`ifndef COMPASS_HEADING_UNIT_MACROS_SVH
`define COMPASS_HEADING_UNIT_MACROS_SVH

// Combinational check sampled on every rising clock edge out of reset.
`define CHU_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("compass heading unit check failed");

// Antecedent in this cycle implies consequent in the next one.
`define CHU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compass heading unit check failed");

`endif

/* design/chu_pkg.sv */
// Package for the compass heading unit: widths, angle constants, arctangent table.
// No dependencies; used by the top level and its checker.
package chu_pkg;

    localparam int IN_W         = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int RAD_W        = 15;
    localparam int DEC_W        = 15;
    localparam int HEAD_W       = 15;

    localparam int ANGLE_STAGES = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_GUARD = 4;

    localparam int DIFF_W       = IN_W + 1;
    localparam int PROD_W       = 32;
    localparam int MAG_W        = PROD_W - 1;
    localparam int POS_W        = $clog2(MAG_W);
    localparam int CW           = SAMPLE_BITS + CORDIC_GUARD + 4;

    localparam int ANG_FRAC     = 22;
    localparam int ANG_W        = 32;
    localparam int H_W          = ANG_W + 2;
    localparam int HSHIFT       = ANG_FRAC - 6;
    localparam int HQ_W         = H_W - HSHIFT + 1;

    localparam int HALF_TURN_Q  = 11520;
    localparam int FULL_TURN_Q  = 23040;

    localparam int S_TDATA_W    = 2 * IN_W;
    localparam int M_TDATA_W    = ((HEAD_W + 7) / 8) * 8;

    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * (2 ** ANG_FRAC));
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * (2 ** ANG_FRAC));
    localparam logic signed [ANG_W-1:0] ROUND_Q = ANG_W'(2 ** (ANG_FRAC - 7));

    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic a_zero;
        logic b_zero;
    } t_side;

    // atan(2^-i) in units of 2^-22 degree
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 32'sd188743680;
            1:       v = 32'sd111421900;
            2:       v = 32'sd58872272;
            3:       v = 32'sd29884485;
            4:       v = 32'sd15000234;
            5:       v = 32'sd7507429;
            6:       v = 32'sd3754631;
            7:       v = 32'sd1877430;
            8:       v = 32'sd938729;
            9:       v = 32'sd469366;
            10:      v = 32'sd234683;
            11:      v = 32'sd117342;
            12:      v = 32'sd58671;
            13:      v = 32'sd29335;
            14:      v = 32'sd14668;
            15:      v = 32'sd7334;
            16:      v = 32'sd3667;
            17:      v = 32'sd1833;
            18:      v = 32'sd917;
            19:      v = 32'sd458;
            20:      v = 32'sd229;
            21:      v = 32'sd115;
            22:      v = 32'sd57;
            23:      v = 32'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/compass_heading_unit.sv */
// Compass heading unit: takes one magnetometer X/Y sample per beat and returns
// the heading in 1/64 degree, computed by the calibration multiply, normalize and
// CORDIC vectoring pipeline (16 arctangent stages). One sample is taken every
// cycle while the output side is ready; a held output beat stalls the whole
// pipeline, nothing is dropped.
// Configuration writes are applied at once and must only happen while idle.
// Depends on chu_pkg.
module compass_heading_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [chu_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [chu_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [chu_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,   // [15:0] mag_x, [31:16] mag_y
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [chu_pkg::M_TDATA_W-1:0]   o_m_axis_tdata    // [14:0] heading, [15] zero
);
    import chu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = CFG_IDX_W'(4);

    localparam logic signed [DEC_W-1:0] DEC_MAX = DEC_W'(HALF_TURN_Q);
    localparam logic signed [DEC_W-1:0] DEC_MIN = -DEC_W'(HALF_TURN_Q);

    // configuration
    logic signed [IN_W-1:0]  r_offset_x, r_offset_y;
    logic [RAD_W-1:0]        r_radius_x, r_radius_y;
    logic signed [DEC_W-1:0] r_decl;
    logic signed [DEC_W-1:0] n_decl;

    always_comb begin
        n_decl = signed'(i_cfg_wdata[DEC_W-1:0]);
        if (n_decl < DEC_MIN) begin
            n_decl = DEC_MIN;
        end else if (n_decl > DEC_MAX) begin
            n_decl = DEC_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_radius_x <= RAD_W'(1024);
            r_radius_y <= RAD_W'(1024);
            r_decl     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_OFFSET_X:    r_offset_x <= signed'(i_cfg_wdata[IN_W-1:0]);
                REG_OFFSET_Y:    r_offset_y <= signed'(i_cfg_wdata[IN_W-1:0]);
                REG_RADIUS_X:    r_radius_x <= i_cfg_wdata[RAD_W-1:0];
                REG_RADIUS_Y:    r_radius_y <= i_cfg_wdata[RAD_W-1:0];
                REG_DECLINATION: r_decl     <= n_decl;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic en;
    logic r_m_valid;
    logic [HEAD_W-1:0] r_heading;

    assign en              = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-HEAD_W){1'b0}}, r_heading};

    // stage 1: remove hard-iron offsets
    logic                     r_v1;
    logic signed [DIFF_W-1:0] r1_xc, r1_yc;
    logic [IN_W-1:0]          mag_x, mag_y;

    assign mag_x = i_s_axis_tdata[IN_W-1:0];
    assign mag_y = i_s_axis_tdata[2*IN_W-1:IN_W];

    // stage 2: soft-iron cross scaling
    logic                       r_v2;
    logic signed [PROD_W-1:0]   r2_a, r2_b;
    logic [RAD_W-1:0]           rx_eff, ry_eff;
    logic signed [DIFF_W+RAD_W:0] prod_a, prod_b;

    assign rx_eff = (r_radius_x == '0) ? RAD_W'(1) : r_radius_x;
    assign ry_eff = (r_radius_y == '0) ? RAD_W'(1) : r_radius_y;
    assign prod_a = r1_yc * signed'({1'b0, rx_eff});
    assign prod_b = r1_xc * signed'({1'b0, ry_eff});

    // stage 3: magnitudes and quadrant flags
    logic               r_v3;
    logic [MAG_W-1:0]   r3_ma, r3_mb;
    t_side              r3_side;
    logic signed [PROD_W-1:0] abs_a, abs_b;

    assign abs_a = r2_a[PROD_W-1] ? -r2_a : r2_a;
    assign abs_b = r2_b[PROD_W-1] ? -r2_b : r2_b;

    // stage 4: leading-one search
    logic               r_v4;
    logic [MAG_W-1:0]   r4_ma, r4_mb;
    t_side              r4_side;
    logic               r4_right;
    logic [POS_W-1:0]   r4_amt;
    logic [MAG_W-1:0]   mag_or;
    logic [POS_W-1:0]   msb_pos;

    assign mag_or = r3_ma | r3_mb;

    always_comb begin
        msb_pos = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (mag_or[k]) begin
                msb_pos = POS_W'(k);
            end
        end
    end

    // stage 5: normalize into the CORDIC start vector
    logic [MAG_W-1:0] sh_a, sh_b;

    always_comb begin
        if (r4_right) begin
            sh_a = r4_ma >> r4_amt;
            sh_b = r4_mb >> r4_amt;
        end else begin
            sh_a = r4_ma << r4_amt;
            sh_b = r4_mb << r4_amt;
        end
    end

    logic                    r_cv [0:ANGLE_STAGES];
    logic signed [CW-1:0]    r_cx [0:ANGLE_STAGES];
    logic signed [CW-1:0]    r_cy [0:ANGLE_STAGES];
    logic signed [ANG_W-1:0] r_cz [0:ANGLE_STAGES];
    t_side                   r_cs [0:ANGLE_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_cv[0]  <= 1'b0;
        end else if (en) begin
            r_v1     <= i_s_axis_tvalid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_cv[0]  <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xc <= {mag_x[IN_W-1], mag_x} - {r_offset_x[IN_W-1], r_offset_x};
            r1_yc <= {mag_y[IN_W-1], mag_y} - {r_offset_y[IN_W-1], r_offset_y};

            r2_a <= prod_a[PROD_W-1:0];
            r2_b <= prod_b[PROD_W-1:0];

            r3_ma          <= abs_a[MAG_W-1:0];
            r3_mb          <= abs_b[MAG_W-1:0];
            r3_side.a_neg  <= r2_a[PROD_W-1];
            r3_side.b_neg  <= r2_b[PROD_W-1];
            r3_side.a_zero <= (r2_a == '0);
            r3_side.b_zero <= (r2_b == '0);

            r4_ma   <= r3_ma;
            r4_mb   <= r3_mb;
            r4_side <= r3_side;
            if (msb_pos >= POS_W'(SAMPLE_BITS)) begin
                r4_right <= 1'b1;
                r4_amt   <= msb_pos - POS_W'(SAMPLE_BITS - 1);
            end else begin
                r4_right <= 1'b0;
                r4_amt   <= POS_W'(SAMPLE_BITS - 1) - msb_pos;
            end

            r_cx[0] <= signed'({{(CW-SAMPLE_BITS-CORDIC_GUARD){1'b0}},
                                sh_a[SAMPLE_BITS-1:0], {CORDIC_GUARD{1'b0}}});
            r_cy[0] <= signed'({{(CW-SAMPLE_BITS-CORDIC_GUARD){1'b0}},
                                sh_b[SAMPLE_BITS-1:0], {CORDIC_GUARD{1'b0}}});
            r_cz[0] <= '0;
            r_cs[0] <= r4_side;
        end
    end

    // CORDIC vectoring stages
    for (genvar gi = 0; gi < ANGLE_STAGES; gi++) begin : g_cordic
        logic signed [CW-1:0] xs, ys;

        assign xs = r_cx[gi] >>> gi;
        assign ys = r_cy[gi] >>> gi;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[gi+1] <= 1'b0;
            end else if (en) begin
                r_cv[gi+1] <= r_cv[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_cy[gi][CW-1]) begin
                    r_cx[gi+1] <= r_cx[gi] + ys;
                    r_cy[gi+1] <= r_cy[gi] - xs;
                    r_cz[gi+1] <= r_cz[gi] + atan_entry(gi);
                end else begin
                    r_cx[gi+1] <= r_cx[gi] - ys;
                    r_cy[gi+1] <= r_cy[gi] + xs;
                    r_cz[gi+1] <= r_cz[gi] - atan_entry(gi);
                end
                r_cs[gi+1] <= r_cs[gi];
            end
        end
    end

    // quadrant restore, rounding, declination, wrap
    logic                    r_vq1, r_vq2, r_vq3;
    logic signed [ANG_W-1:0] r_q1_t;
    logic                    r_q1_bneg;
    logic signed [H_W-1:0]   r_q2_h;
    logic signed [HQ_W-1:0]  r_q3_s;

    t_side                   fin_side;
    logic signed [ANG_W-1:0] t_sel, t_quad;
    logic signed [H_W-1:0]   t_ext, h_bias, h_sum;
    logic [HQ_W-2:0]         h_q;
    logic signed [HQ_W-1:0]  s_sum, s_wrap;

    assign fin_side = r_cs[ANGLE_STAGES];

    always_comb begin
        if (fin_side.b_zero) begin
            t_sel = '0;
        end else if (fin_side.a_zero) begin
            t_sel = ANG_90;
        end else begin
            t_sel = r_cz[ANGLE_STAGES];
        end
        t_quad = fin_side.a_neg ? (ANG_180 - t_sel) : t_sel;
    end

    assign t_ext  = {{(H_W-ANG_W){r_q1_t[ANG_W-1]}}, r_q1_t};
    assign h_bias = H_W'(ANG_180) + H_W'(ROUND_Q);
    assign h_sum  = r_q1_bneg ? (h_bias - t_ext) : (h_bias + t_ext);

    assign h_q   = r_q2_h[H_W-1] ? '0 : r_q2_h[H_W-1:HSHIFT];
    assign s_sum = signed'({1'b0, h_q}) - HQ_W'(HALF_TURN_Q)
                 + {{(HQ_W-DEC_W){r_decl[DEC_W-1]}}, r_decl};

    always_comb begin
        if (r_q3_s < 0) begin
            s_wrap = r_q3_s + HQ_W'(FULL_TURN_Q);
        end else if (r_q3_s >= HQ_W'(FULL_TURN_Q)) begin
            s_wrap = r_q3_s - HQ_W'(FULL_TURN_Q);
        end else begin
            s_wrap = r_q3_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq1     <= 1'b0;
            r_vq2     <= 1'b0;
            r_vq3     <= 1'b0;
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_vq1     <= r_cv[ANGLE_STAGES];
            r_vq2     <= r_vq1;
            r_vq3     <= r_vq2;
            r_m_valid <= r_vq3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_t    <= t_quad;
            r_q1_bneg <= fin_side.b_neg;
            r_q2_h    <= h_sum;
            r_q3_s    <= s_sum;
            r_heading <= s_wrap[HEAD_W-1:0];
        end
    end

endmodule

/* design/chu_checker.sv */
// Port-level checker for the compass heading unit, bound to the top level.
// Depends on chu_pkg and compass_heading_unit_macros.svh.
`include "compass_heading_unit_macros.svh"

module chu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [chu_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);
    import chu_pkg::*;

    logic held;
    logic heading_ok;
    logic ready_ok;

    assign held       = o_m_axis_tvalid && !i_m_axis_tready;
    assign heading_ok = !o_m_axis_tvalid
                     || (o_m_axis_tdata < M_TDATA_W'(FULL_TURN_Q));
    assign ready_ok   = o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready);

    // held output beat keeps its value
    `CHU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, held, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // heading wraps into one turn
    `CHU_ASSERT(a_heading_range, i_clk, i_rst_n, heading_ok)
    // input side stalls only behind a held output beat
    `CHU_ASSERT(a_ready_follows_out, i_clk, i_rst_n, ready_ok)

endmodule

bind compass_heading_unit chu_checker u_chu_checker (.*);
